// ----- design/lpd_pkg.sv -----
// Shared constants and types for the length-prefixed packet deframer.
`default_nettype none

package lpd_pkg;

    // Parser phases.
    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_LENGTH = 3'd1;
    localparam logic [2:0] PH_META   = 3'd2;
    localparam logic [2:0] PH_BIN    = 3'd3;
    localparam logic [2:0] PH_DROP   = 3'd4;

    // Content byte kinds.
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_META = 2'd1;
    localparam logic [1:0] KIND_BIN  = 2'd2;

    // Packet status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_SHORT     = 2'd1;
    localparam logic [1:0] ST_STR_LONG  = 2'd2;

    // Header byte boundaries: each field ends before the given position.
    localparam logic [4:0] TYPE_END   = 5'd2;
    localparam logic [4:0] PROPS_END  = 5'd6;
    localparam logic [4:0] TARGET_END = 5'd10;
    localparam logic [4:0] GROUP_END  = 5'd14;
    localparam logic [4:0] HEADER_LEN = 5'd18;

    // Position of the final byte of the string length word.
    localparam logic [4:0] LEN_WORD_LAST = 5'd3;
    localparam logic [31:0] LEN_WORD_BYTES = 32'd4;

    localparam int LPD_QUEUE_DEPTH = 2;

    localparam logic [31:0] GROUP_END_MASK_RESET = 32'd1;

    // One result on its way from the parser to the output stage.
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [15:0] type_code;
        logic [31:0] props;
        logic [31:0] target;
        logic [31:0] group;
        logic [1:0]  status;
        logic        last;
    } lpd_entry_t;

endpackage

`default_nettype wire

// ----- design/lpd_front.sv -----
// Byte parser: tracks header, length word and payload, and builds result entries.
`default_nettype none

module lpd_front
    import lpd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    input  wire logic [7:0] s_data_byte,
    output logic            s_ready,
    input  wire logic       push_ready,
    output logic            push_valid,
    output lpd_entry_t      push_entry
);

    logic [2:0]  phase_reg, phase_next;
    logic [4:0]  pos_reg, pos_next;
    logic [15:0] type_reg, type_next;
    logic [31:0] props_reg, props_next;
    logic [31:0] target_reg, target_next;
    logic [31:0] group_reg, group_next;
    logic [31:0] plen_reg, plen_next;
    logic [31:0] slen_reg, slen_next;
    logic [31:0] left_reg, left_next;
    logic [1:0]  err_reg, err_next;

    logic        accept;
    logic [4:0]  pos_eff;
    logic [31:0] plen_shifted;
    logic [31:0] slen_shifted;
    logic [31:0] left_after_word;
    logic        emit;
    logic        emit_last;
    logic [1:0]  emit_kind;

    assign s_ready = push_ready;
    assign accept  = s_valid && push_ready;

    assign pos_eff         = (pos_reg >= HEADER_LEN) ? 5'd0 : pos_reg;
    assign plen_shifted    = {plen_reg[23:0], s_data_byte};
    assign slen_shifted    = {slen_reg[23:0], s_data_byte};
    assign left_after_word = plen_reg - LEN_WORD_BYTES;

    always_comb begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        type_next   = type_reg;
        props_next  = props_reg;
        target_next = target_reg;
        group_next  = group_reg;
        plen_next   = plen_reg;
        slen_next   = slen_reg;
        left_next   = left_reg;
        err_next    = err_reg;
        emit        = 1'b0;
        emit_last   = 1'b0;
        emit_kind   = KIND_NONE;

        if (accept) begin
            unique case (phase_reg)
                PH_LENGTH: begin
                    slen_next = slen_shifted;
                    if (pos_reg == LEN_WORD_LAST) begin
                        pos_next  = 5'd0;
                        left_next = left_after_word;
                        if (slen_shifted > left_after_word) begin
                            err_next   = ST_STR_LONG;
                            phase_next = PH_DROP;
                        end else begin
                            phase_next = (slen_shifted != 32'd0) ? PH_META : PH_BIN;
                        end
                        if (left_after_word == 32'd0) begin
                            emit      = 1'b1;
                            emit_last = 1'b1;
                        end
                    end else begin
                        pos_next = pos_reg + 5'd1;
                    end
                end
                PH_META, PH_BIN: begin
                    emit      = 1'b1;
                    emit_kind = (phase_reg == PH_META) ? KIND_META : KIND_BIN;
                    emit_last = (left_reg == 32'd1);
                    left_next = left_reg - 32'd1;
                    if (phase_reg == PH_META) begin
                        slen_next = slen_reg - 32'd1;
                        if (slen_reg == 32'd1) begin
                            phase_next = PH_BIN;
                        end
                    end
                end
                PH_DROP: begin
                    left_next = left_reg - 32'd1;
                    if (left_reg == 32'd1) begin
                        emit      = 1'b1;
                        emit_last = 1'b1;
                    end
                end
                default: begin
                    // Header bytes; unused phase codes are handled as header too.
                    phase_next = PH_HEADER;
                    if (pos_eff < TYPE_END) begin
                        type_next = {type_reg[7:0], s_data_byte};
                    end else if (pos_eff < PROPS_END) begin
                        props_next = {props_reg[23:0], s_data_byte};
                    end else if (pos_eff < TARGET_END) begin
                        target_next = {target_reg[23:0], s_data_byte};
                    end else if (pos_eff < GROUP_END) begin
                        group_next = {group_reg[23:0], s_data_byte};
                    end else begin
                        plen_next = plen_shifted;
                    end
                    if (pos_eff == HEADER_LEN - 5'd1) begin
                        pos_next  = 5'd0;
                        err_next  = ST_OK;
                        slen_next = 32'd0;
                        if (plen_shifted < LEN_WORD_BYTES) begin
                            err_next  = ST_SHORT;
                            left_next = plen_shifted;
                            if (plen_shifted == 32'd0) begin
                                emit      = 1'b1;
                                emit_last = 1'b1;
                            end else begin
                                phase_next = PH_DROP;
                            end
                        end else begin
                            phase_next = PH_LENGTH;
                        end
                    end else begin
                        pos_next = pos_eff + 5'd1;
                    end
                end
            endcase

            // The final byte of a packet always returns the parser to the header.
            if (emit_last) begin
                phase_next = PH_HEADER;
                pos_next   = 5'd0;
            end
        end
    end

    always_comb begin
        push_valid           = emit;
        push_entry.kind      = emit_kind;
        push_entry.data      = (emit_kind != KIND_NONE) ? s_data_byte : 8'd0;
        push_entry.type_code = type_next;
        push_entry.props     = props_next;
        push_entry.target    = target_next;
        push_entry.group     = group_next;
        push_entry.status    = emit_last ? err_next : ST_OK;
        push_entry.last      = emit_last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            pos_reg   <= 5'd0;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
        end
        type_reg   <= type_next;
        props_reg  <= props_next;
        target_reg <= target_next;
        group_reg  <= group_next;
        plen_reg   <= plen_next;
        slen_reg   <= slen_next;
        left_reg   <= left_next;
        err_reg    <= err_next;
    end

endmodule

`default_nettype wire

// ----- design/lpd_queue.sv -----
// Short first-in first-out queue of result entries between parser and output stage.
`default_nettype none

module lpd_queue
    import lpd_pkg::*;
#(
    parameter int DEPTH = LPD_QUEUE_DEPTH
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire lpd_entry_t in_entry,
    output logic            out_valid,
    input  wire logic       out_ready,
    output lpd_entry_t      out_entry
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    lpd_entry_t       entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_FULL);
    assign out_valid = (count_reg != '0);
    assign out_entry = entries[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            entries[wr_ptr_reg] <= in_entry;
        end
    end

endmodule

`default_nettype wire

// ----- design/lpd_back.sv -----
// Output stage: holds the group end mask, forms the end-of-group flag, drives the result port.
`default_nettype none

module lpd_back
    import lpd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        pop_valid,
    output logic             pop_ready,
    input  wire lpd_entry_t  pop_entry,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_byte_kind,
    output logic [7:0]       m_content_byte,
    output logic [15:0]      m_type_code,
    output logic [31:0]      m_target,
    output logic [31:0]      m_group,
    output logic             m_end_of_group,
    output logic [1:0]       m_status,
    output logic             m_last_of_packet
);

    logic [31:0] mask_reg;
    logic        valid_reg, valid_next;
    logic [1:0]  kind_reg;
    logic [7:0]  data_reg;
    logic [15:0] type_reg;
    logic [31:0] target_reg;
    logic [31:0] group_reg;
    logic        eog_reg, eog_next;
    logic [1:0]  status_reg;
    logic        last_reg;
    logic        load;

    assign pop_ready  = !valid_reg || m_ready;
    assign load       = pop_valid && pop_ready;
    assign valid_next = load || (valid_reg && !m_ready);
    assign eog_next   = pop_entry.last && ((pop_entry.props & mask_reg) != 32'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg  <= GROUP_END_MASK_RESET;
            valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                mask_reg <= cfg_wdata;
            end
            valid_reg <= valid_next;
        end
        if (load) begin
            kind_reg   <= pop_entry.kind;
            data_reg   <= pop_entry.data;
            type_reg   <= pop_entry.type_code;
            target_reg <= pop_entry.target;
            group_reg  <= pop_entry.group;
            eog_reg    <= eog_next;
            status_reg <= pop_entry.status;
            last_reg   <= pop_entry.last;
        end
    end

    assign m_valid          = valid_reg;
    assign m_byte_kind      = kind_reg;
    assign m_content_byte   = data_reg;
    assign m_type_code      = type_reg;
    assign m_target         = target_reg;
    assign m_group          = group_reg;
    assign m_end_of_group   = eog_reg;
    assign m_status         = status_reg;
    assign m_last_of_packet = last_reg;

endmodule

`default_nettype wire

// ----- design/length_prefixed_packet_deframer.sv -----
// Top level of the length-prefixed packet deframer: parser, entry queue and output stage.
// Throughput: one byte per cycle; s_ready drops only while the entry queue is full.
// Path: a byte that yields a result is written into the entry queue when it is accepted,
// then moves on into the output register that drives the m_ port once that register is free.
// Reset (aresetn low, synchronous): parser to the header phase, queue and output empty,
// group end mask set to 1.
`default_nettype none

module length_prefixed_packet_deframer
    import lpd_pkg::*;
#(
    parameter int QUEUE_DEPTH = LPD_QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_byte_kind,
    output logic [7:0]       m_content_byte,
    output logic [15:0]      m_type_code,
    output logic [31:0]      m_target,
    output logic [31:0]      m_group,
    output logic             m_end_of_group,
    output logic [1:0]       m_status,
    output logic             m_last_of_packet
);

    logic       push_valid;
    logic       push_ready;
    lpd_entry_t push_entry;
    logic       pop_valid;
    logic       pop_ready;
    lpd_entry_t pop_entry;

    lpd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_data_byte (s_data_byte),
        .s_ready     (s_ready),
        .push_ready  (push_ready),
        .push_valid  (push_valid),
        .push_entry  (push_entry)
    );

    lpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_entry  (push_entry),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_entry (pop_entry)
    );

    lpd_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .pop_valid        (pop_valid),
        .pop_ready        (pop_ready),
        .pop_entry        (pop_entry),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_byte_kind      (m_byte_kind),
        .m_content_byte   (m_content_byte),
        .m_type_code      (m_type_code),
        .m_target         (m_target),
        .m_group          (m_group),
        .m_end_of_group   (m_end_of_group),
        .m_status         (m_status),
        .m_last_of_packet (m_last_of_packet)
    );

endmodule

`default_nettype wire
